[design/hsrag_pkg.sv]
// shared types and codes for the hyperslab run address generator
`default_nettype none
package hsrag_pkg;

  localparam int MAX_DIMS_DEF = 8;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_NEXT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_RUN       = 3'd0,
    STAT_ACCEPT    = 3'd1,
    STAT_BAD_COORD = 3'd2,
    STAT_BAD_EDGE  = 3'd3,
    STAT_IDLE      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_BASE       = 2'd0,
    CFG_REC_STRIDE = 2'd1,
    CFG_HAS_REC    = 2'd2,
    CFG_NUM_DIMS   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_FETCH,
    S_CHK,
    S_CHKREC,
    S_EDGE,
    S_PMUL,
    S_PADD,
    S_ZERO,
    S_OMUL,
    S_OADD,
    S_RIP,
    S_OUT
  } fsm_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  dim_index;
    logic [31:0] start_index;
    logic [31:0] edge_length;
    logic [31:0] dim_extent;
    logic [39:0] dim_stride;
    logic        is_write;
  } item_t;

  typedef struct packed {
    logic [47:0] offset;
    logic [31:0] run_count;
    logic        last;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic [47:0] base_offset;
    logic [39:0] record_stride;
    logic        has_record_dim;
    logic [3:0]  num_dims;
  } cfg_t;

endpackage
`default_nettype wire

[design/hsrag_front.sv]
// front end: accepts items into a two-entry queue
`default_nettype none
module hsrag_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  hsrag_pkg::item_t    in_item,
  output logic                q_valid,
  input  wire                 q_pop,
  output hsrag_pkg::item_t    q_item
);
  import hsrag_pkg::*;

  item_t      q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= in_item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

[design/hsrag_back.sv]
// back end: descriptor tables, start checks, run offsets and coordinate ripple
`default_nettype none
module hsrag_back #(
  parameter int MAX_DIMS = hsrag_pkg::MAX_DIMS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  hsrag_pkg::cfg_t     cfg,
  input  wire                 q_valid,
  output logic                q_pop,
  input  hsrag_pkg::item_t    q_item,
  output logic                m_valid,
  input  wire                 m_ready,
  output hsrag_pkg::res_t     m_res
);
  import hsrag_pkg::*;

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int NW = $clog2(MAX_DIMS + 1);
  localparam int CW = (NW > 4) ? NW : 4;

  logic [31:0] start_tab  [MAX_DIMS];
  logic [31:0] edge_tab   [MAX_DIMS];
  logic [31:0] extent_tab [MAX_DIMS];
  logic [39:0] stride_tab [MAX_DIMS];
  logic [31:0] coord      [MAX_DIMS];

  fsm_t        state;
  fsm_t        state_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] split;
  logic [CW-1:0] split_dim;
  logic [63:0] len;
  logic [63:0] run_len;
  logic [63:0] plo;
  logic [63:0] phi;
  logic [47:0] sum;
  logic        act;
  logic        active;
  logic        wt;
  logic        is_next;
  logic [31:0] rec_cnt;
  res_t        res;
  res_t        fetch_res;

  logic [CW-1:0] n;
  logic [CW-1:0] lo_w;
  logic          lo;
  logic [CW-1:0] idx_m1;
  logic [DW-1:0] a;
  logic [31:0]   c_sel;
  logic [31:0]   c0_sel;
  logic [39:0]   stride_sel;
  logic [CW-1:0] s_lim;
  logic          edge_bad;
  logic          edge_part;
  logic          rip_inc;
  logic          rec_short;
  logic [31:0]   mul_a_lo;
  logic [31:0]   mul_a_hi;
  logic [31:0]   mul_b;
  logic [63:0]   prod_lo;
  logic [63:0]   prod_hi;
  logic [64:0]   len_sum;
  logic          len_ovf;
  logic          dim_ok;
  logic [DW-1:0] la;

  assign n      = (CW'(cfg.num_dims) > CW'(MAX_DIMS)) ? CW'(MAX_DIMS) : CW'(cfg.num_dims);
  assign lo     = cfg.has_record_dim && (n != '0);
  assign lo_w   = {{(CW-1){1'b0}}, lo};
  assign idx_m1 = idx - 1'b1;
  assign a      = (state == S_EDGE || state == S_RIP) ? idx_m1[DW-1:0] : idx[DW-1:0];
  assign c_sel  = is_next ? coord[a] : start_tab[a];
  assign c0_sel = is_next ? coord[0] : start_tab[0];
  assign stride_sel = (lo && idx == '0) ? cfg.record_stride : stride_tab[a];
  assign s_lim  = (split_dim < n) ? split_dim : n;
  assign edge_bad  = edge_tab[a] > (extent_tab[a] - start_tab[a]);
  assign edge_part = edge_tab[a] < extent_tab[a];
  assign rip_inc   = ({1'b0, coord[a]} + 33'd1) < ({1'b0, start_tab[a]} + {1'b0, edge_tab[a]});
  assign rec_short = lo && (c0_sel >= rec_cnt);
  assign dim_ok    = (int'(q_item.dim_index) < MAX_DIMS);
  assign la        = DW'(q_item.dim_index);

  // one shared pair of 32x32 multipliers for run length and offsets
  assign mul_a_lo = (state == S_PMUL) ? len[31:0]  : stride_sel[31:0];
  assign mul_a_hi = (state == S_PMUL) ? len[63:32] : {24'b0, stride_sel[39:32]};
  assign mul_b    = (state == S_PMUL) ? edge_tab[a] : coord[a];
  assign prod_lo  = {32'b0, mul_a_lo} * {32'b0, mul_b};
  assign prod_hi  = {32'b0, mul_a_hi} * {32'b0, mul_b};
  assign len_sum  = {1'b0, phi[31:0], 32'b0} + {1'b0, plo};
  assign len_ovf  = (phi[63:32] != 32'b0) || len_sum[64];

  assign q_pop = (state == S_FETCH) && q_valid;

  // result of an item that is answered straight from fetch
  always_comb begin
    fetch_res = '{offset: 48'b0, run_count: 32'b0, last: 1'b0, status: STAT_IDLE};
    case (q_item.kind)
      KIND_LOAD: fetch_res.status = STAT_ACCEPT;
      KIND_START: begin
        if (n == '0) begin
          fetch_res.status = STAT_ACCEPT;
        end
      end
      KIND_NEXT: begin
        if (active && n == '0) begin
          fetch_res.offset    = cfg.base_offset;
          fetch_res.run_count = 32'd1;
          fetch_res.last      = 1'b1;
          fetch_res.status    = STAT_RUN;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_FETCH: begin
        if (q_valid) begin
          case (q_item.kind)
            KIND_START: state_next = (n == '0) ? S_OUT : S_CHK;
            KIND_NEXT:  state_next = (!active || n == '0) ? S_OUT : S_CHK;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_CHK: begin
        if (idx >= n) begin
          state_next = S_CHKREC;
        end else if (c_sel >= extent_tab[a]) begin
          state_next = S_OUT;
        end
      end
      S_CHKREC: begin
        if (rec_short && !wt) begin
          state_next = S_OUT;
        end else begin
          state_next = is_next ? S_OMUL : S_EDGE;
        end
      end
      S_EDGE: begin
        if (idx <= lo_w) begin
          state_next = S_PMUL;
        end else if (edge_bad) begin
          state_next = S_OUT;
        end else if (edge_part) begin
          state_next = S_PMUL;
        end
      end
      S_PMUL: state_next = (idx >= n) ? S_ZERO : S_PADD;
      S_PADD: state_next = S_PMUL;
      S_ZERO: begin
        if (split == '0 || idx >= split) begin
          state_next = S_OUT;
        end
      end
      S_OMUL: state_next = (idx >= n) ? S_RIP : S_OADD;
      S_OADD: state_next = S_OMUL;
      S_RIP: begin
        if (idx == '0 || rip_inc) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid || m_ready) begin
          state_next = S_FETCH;
        end
      end
      default: state_next = S_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_FETCH: begin
        if (q_valid) begin
          res <= fetch_res;
          case (q_item.kind)
            KIND_LOAD: begin
              if (dim_ok) begin
                start_tab[la]  <= q_item.start_index;
                edge_tab[la]   <= q_item.edge_length;
                extent_tab[la] <= q_item.dim_extent;
                stride_tab[la] <= q_item.dim_stride;
              end
            end
            KIND_START: begin
              is_next <= 1'b0;
              idx     <= lo_w;
              for (int i = 0; i < MAX_DIMS; i++) begin
                coord[i] <= start_tab[i];
              end
            end
            KIND_NEXT: begin
              is_next <= 1'b1;
              idx     <= lo_w;
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (idx < n) begin
          if (c_sel >= extent_tab[a]) begin
            res.status <= STAT_BAD_COORD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
      end
      S_CHKREC: begin
        if (rec_short && !wt) begin
          res.status <= STAT_BAD_COORD;
        end else if (is_next) begin
          idx <= '0;
          sum <= 48'b0;
        end else begin
          idx <= n;
        end
      end
      S_EDGE: begin
        len <= 64'd1;
        if (idx <= lo_w) begin
          split <= lo_w;
          idx   <= lo_w;
        end else if (edge_bad) begin
          res.status <= STAT_BAD_EDGE;
        end else if (edge_part) begin
          split <= idx_m1;
          idx   <= idx_m1;
        end else begin
          idx <= idx_m1;
        end
      end
      S_PMUL: begin
        if (idx >= n) begin
          idx <= '0;
          act <= (split == '0) ? (len != 64'b0) : 1'b1;
        end else begin
          plo <= prod_lo;
          phi <= prod_hi;
        end
      end
      S_PADD: begin
        len <= len_ovf ? {64{1'b1}} : len_sum[63:0];
        idx <= idx + 1'b1;
      end
      S_ZERO: begin
        if (split == '0 || idx >= split) begin
          res.status <= STAT_ACCEPT;
        end else begin
          if (edge_tab[a] == 32'b0) begin
            act <= 1'b0;
          end
          idx <= idx + 1'b1;
        end
      end
      S_OMUL: begin
        if (idx >= n) begin
          res.offset    <= cfg.base_offset + sum;
          res.run_count <= (run_len[63:32] != 32'b0) ? 32'hFFFF_FFFF : run_len[31:0];
          res.status    <= STAT_RUN;
          idx           <= s_lim;
        end else begin
          plo <= prod_lo;
          phi <= prod_hi;
        end
      end
      S_OADD: begin
        sum <= sum + plo[47:0] + {phi[15:0], 32'b0};
        idx <= idx + 1'b1;
      end
      S_RIP: begin
        if (idx == '0) begin
          res.last <= 1'b1;
        end else if (rip_inc) begin
          coord[a] <= coord[a] + 32'd1;
        end else begin
          coord[a] <= start_tab[a];
          idx      <= idx_m1;
        end
      end
      S_OUT: begin
        if (!m_valid || m_ready) begin
          m_res <= res;
        end
      end
      default: ;
    endcase

    if (rst) begin
      state     <= S_FETCH;
      active    <= 1'b0;
      wt        <= 1'b0;
      rec_cnt   <= 32'b0;
      split_dim <= '0;
      run_len   <= 64'b0;
      m_valid   <= 1'b0;
    end else begin
      state <= state_next;
      // output register: load a new result or drop the one taken
      if (state == S_OUT && (!m_valid || m_ready)) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        S_FETCH: begin
          if (q_valid) begin
            case (q_item.kind)
              KIND_LOAD: active <= 1'b0;
              KIND_START: begin
                wt     <= q_item.is_write;
                active <= (n == '0);
                if (n == '0) begin
                  split_dim <= '0;
                  run_len   <= 64'd1;
                end
              end
              KIND_NEXT: begin
                if (n == '0) begin
                  active <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHK: begin
          if (idx < n && c_sel >= extent_tab[a]) begin
            active <= 1'b0;
          end
        end
        S_CHKREC: begin
          if (rec_short) begin
            if (!wt) begin
              active <= 1'b0;
            end else begin
              rec_cnt <= (c0_sel == 32'hFFFF_FFFF) ? c0_sel : c0_sel + 32'd1;
            end
          end
        end
        S_ZERO: begin
          if (split == '0 || idx >= split) begin
            run_len   <= len;
            split_dim <= split;
            active    <= act;
          end
        end
        S_RIP: begin
          if (idx == '0) begin
            active <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/hyperslab_run_address_generator_unit.sv]
// top level of the hyperslab run address generator
//
//  channel  direction  handshake        contents
//  s_axis   in         tvalid/tready    one command item (load, start, next)
//  m_axis   out        tvalid/tready    one result item per command
//  cfg      in         cfg_we           register write, no read-back
//
// the back end walks one dimension per cycle for checks and ripple, and it
// multiplies and accumulates each dimension's term of run length and offset in
// separate multiply and add states (shared 32x32 multipliers).
// reset (rst, synchronous) clears control state; descriptor tables are
// undefined until loaded. a two-entry queue takes items while the back end
// works, and a result register holds the answer while m_axis is stalled.
`default_nettype none
module hyperslab_run_address_generator_unit #(
  parameter int MAX_DIMS = hsrag_pkg::MAX_DIMS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [143:0] s_axis_tdata,   // dim_index, start_index, edge_length,
                                       // dim_extent, dim_stride, is_write, zero pad
  input  wire  [1:0]   s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // offset, run_count
  output logic         m_axis_tlast,   // last run of the transfer
  output logic [2:0]   m_axis_tuser,   // status
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [47:0]  cfg_data
);
  import hsrag_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  res_t  m_res;

  // unpack the command fields, lowest bit first
  assign in_item.kind        = kind_t'(s_axis_tuser);
  assign in_item.dim_index   = s_axis_tdata[2:0];
  assign in_item.start_index = s_axis_tdata[34:3];
  assign in_item.edge_length = s_axis_tdata[66:35];
  assign in_item.dim_extent  = s_axis_tdata[98:67];
  assign in_item.dim_stride  = s_axis_tdata[138:99];
  assign in_item.is_write    = s_axis_tdata[139];

  // configuration registers, read live by the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_offset    <= 48'b0;
      cfg.record_stride  <= 40'b0;
      cfg.has_record_dim <= 1'b0;
      cfg.num_dims       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE:       cfg.base_offset    <= cfg_data;
        CFG_REC_STRIDE: cfg.record_stride  <= cfg_data[39:0];
        CFG_HAS_REC:    cfg.has_record_dim <= cfg_data[0];
        CFG_NUM_DIMS:   cfg.num_dims       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  hsrag_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  hsrag_back #(
    .MAX_DIMS (MAX_DIMS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (m_res)
  );

  assign m_axis_tdata = {m_res.run_count, m_res.offset};
  assign m_axis_tlast = m_res.last;
  assign m_axis_tuser = m_res.status;
endmodule
`default_nettype wire

[tb/hyperslab_run_address_generator_checker.sv]
// checker for the hyperslab run address generator: predicts each result and compares
`timescale 1ns / 1ps
module hyperslab_run_address_generator_checker (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [143:0] s_axis_tdata,
  input  wire  [1:0]   s_axis_tuser,
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire  [79:0]  m_axis_tdata,
  input  wire          m_axis_tlast,
  input  wire  [2:0]   m_axis_tuser,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [47:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import hsrag_pkg::*;

  localparam int NDIM = MAX_DIMS_DEF;

  logic [47:0] base_q;
  logic [39:0] rec_stride_q;
  logic        has_rec_q;
  logic [3:0]  ndims_q;

  logic [31:0] start_tab [NDIM];
  logic [31:0] edge_tab [NDIM];
  logic [31:0] extent_tab [NDIM];
  logic [39:0] stride_tab [NDIM];
  logic [31:0] coord [NDIM];
  int          split_q;
  logic [63:0] run_len_q;
  logic        active_q;
  logic        writing_q;
  logic [31:0] rec_count_q;

  res_t run_queue [$];

  function automatic int dims_in_use();
    return (ndims_q < NDIM) ? int'(ndims_q) : NDIM;
  endfunction

  function automatic int lowest_dim(int n);
    return (has_rec_q && n > 0) ? 1 : 0;
  endfunction

  // 1 when the coordinates are out of range; a write may grow the record count
  function automatic bit coords_bad(int n);
    for (int i = lowest_dim(n); i < n; i++)
      if (coord[i] >= extent_tab[i]) return 1;
    if (lowest_dim(n) != 0 && coord[0] >= rec_count_q) begin
      if (!writing_q) return 1;
      rec_count_q = (coord[0] == 32'hFFFF_FFFF) ? coord[0] : coord[0] + 32'd1;
    end
    return 0;
  endfunction

  function automatic res_t predict_run(item_t it);
    res_t r;
    int n;
    int lo;
    int split;
    int s;
    bit done;
    logic [63:0] len;
    logic [127:0] prod;
    logic [63:0] sum;
    r = '0;
    r.status = STAT_ACCEPT;
    n = dims_in_use();
    case (it.kind)
      KIND_LOAD: begin
        active_q = 0;
        start_tab[it.dim_index]  = it.start_index;
        edge_tab[it.dim_index]   = it.edge_length;
        extent_tab[it.dim_index] = it.dim_extent;
        stride_tab[it.dim_index] = it.dim_stride;
      end
      KIND_START: begin
        writing_q = it.is_write;
        active_q = 0;
        for (int i = 0; i < NDIM; i++) coord[i] = start_tab[i];
        if (n == 0) begin
          split_q = 0;
          run_len_q = 1;
          active_q = 1;
        end else if (coords_bad(n)) begin
          r.status = STAT_BAD_COORD;
        end else begin
          lo = lowest_dim(n);
          split = lo;
          // walk inward-out until a dimension is only partly covered
          for (int i = n - 1; i >= lo; i--) begin
            if (edge_tab[i] > extent_tab[i] - start_tab[i]) begin
              r.status = STAT_BAD_EDGE;
              return r;
            end
            if (edge_tab[i] < extent_tab[i]) begin
              split = i;
              break;
            end
          end
          len = 1;
          for (int i = split; i < n; i++) begin
            prod = len * edge_tab[i];
            len = (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
          end
          split_q = split;
          run_len_q = len;
          if (split == 0) active_q = (len != 0);
          else begin
            active_q = 1;
            for (int i = 0; i < split; i++) if (edge_tab[i] == 0) active_q = 0;
          end
        end
      end
      KIND_NEXT: begin
        r.status = STAT_RUN;
        if (!active_q) r.status = STAT_IDLE;
        else if (n == 0) begin
          r.offset = base_q;
          r.run_count = 1;
          r.last = 1;
          active_q = 0;
        end else if (coords_bad(n)) begin
          r.status = STAT_BAD_COORD;
          active_q = 0;
        end else begin
          sum = 0;
          for (int i = lowest_dim(n); i < n; i++) sum += stride_tab[i] * 64'(coord[i]);
          if (lowest_dim(n) != 0) sum += rec_stride_q * 64'(coord[0]);
          r.offset = 48'(base_q + sum);
          r.run_count = (run_len_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : run_len_q[31:0];
          s = (split_q < n) ? split_q : n;
          done = 1;
          // ripple the outer coordinates
          for (int d = s - 1; d >= 0; d--) begin
            if ({32'd0, coord[d]} + 64'd1 < {32'd0, start_tab[d]} + {32'd0, edge_tab[d]}) begin
              coord[d]++;
              done = 0;
              break;
            end
            coord[d] = start_tab[d];
          end
          if (done) begin
            r.last = 1;
            active_q = 0;
          end
        end
      end
      default: r.status = STAT_IDLE;
    endcase
    return r;
  endfunction

  item_t it_in;
  res_t  got;
  res_t  want;

  assign pending = run_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      base_q = '0;
      rec_stride_q = '0;
      has_rec_q = 0;
      ndims_q = 4'd1;
      split_q = 0;
      run_len_q = '0;
      active_q = 0;
      writing_q = 0;
      rec_count_q = '0;
      fail_count = 0;
      run_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BASE:       base_q = cfg_data;
          CFG_REC_STRIDE: rec_stride_q = cfg_data[39:0];
          CFG_HAS_REC:    has_rec_q = cfg_data[0];
          CFG_NUM_DIMS:   ndims_q = cfg_data[3:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.offset = m_axis_tdata[47:0];
        got.run_count = m_axis_tdata[79:48];
        got.last = m_axis_tlast;
        got.status = status_t'(m_axis_tuser);
        if (run_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %p", got);
          fail_count = fail_count + 1;
        end else begin
          want = run_queue.pop_front();
          if (got.offset !== want.offset || got.run_count !== want.run_count
              || got.last !== want.last || got.status !== want.status) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
            fail_count = fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it_in.kind = kind_t'(s_axis_tuser);
        it_in.dim_index = s_axis_tdata[2:0];
        it_in.start_index = s_axis_tdata[34:3];
        it_in.edge_length = s_axis_tdata[66:35];
        it_in.dim_extent = s_axis_tdata[98:67];
        it_in.dim_stride = s_axis_tdata[138:99];
        it_in.is_write = s_axis_tdata[139];
        run_queue.push_back(predict_run(it_in));
      end
    end
  end
endmodule

[tb/hyperslab_run_address_generator_unit_test.sv]
// stimulus and verdict for the hyperslab run address generator
`timescale 1ns / 1ps
module hyperslab_run_address_generator_unit_test;
  import hsrag_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  wire          s_axis_tready;
  logic [143:0] s_axis_tdata = '0;  // dim_index, start, edge, extent, stride, is_write
  logic [1:0]   s_axis_tuser = '0;  // kind
  wire          m_axis_tvalid;
  logic         m_axis_tready = 0;
  wire  [79:0]  m_axis_tdata;       // offset, run_count
  wire          m_axis_tlast;
  wire  [2:0]   m_axis_tuser;       // status
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_no = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit hold_start = 0;
  bit hold_taken = 0;
  int hold_left = 0;

  always #10 clk = ~clk;

  hyperslab_run_address_generator_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hyperslab_run_address_generator_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, a calm stretch, and one long hold-off so the
  // input queue fills and the block has to back-pressure the sender
  always @(negedge clk) begin
    cycle_no <= cycle_no + 1;
    if (hold_start && !hold_taken) begin
      hold_taken    <= 1;
      hold_left     <= 400;
      m_axis_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 0;
    end else if (cycle_no >= 800 && cycle_no < 2000) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(99) >= 36);
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one command item; entered and left at a falling edge
  task automatic send_cmd(kind_t k, logic [2:0] di, logic [31:0] st, logic [31:0] ed,
                          logic [31:0] ex, logic [39:0] sd, logic wr);
    // sender idles too, except in a calm stretch of items
    if (!(items_sent >= 400 && items_sent < 700) && $urandom_range(99) < 36) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = k;
    s_axis_tdata = {4'b0, wr, sd, ex, ed, st, di};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // register writes happen only once the block has drained
  task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
    s_axis_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  task automatic load_dim(int d, logic [31:0] st, logic [31:0] ed, logic [31:0] ex);
    send_cmd(KIND_LOAD, 3'(d), st, ed, ex, rand40(), 1'($urandom_range(1)));
  endtask

  // one well-formed transfer with random content; flaw picks a broken variant
  // 0 clean, 1 bad start coordinate, 2 bad edge, 3 zero edge somewhere
  task automatic run_transfer(int nd, bit rec, int flaw, int nexts);
    int used;
    int bad_dim;
    logic [31:0] ex, st, ed;
    write_reg(CFG_BASE, 48'({$urandom, $urandom}));
    write_reg(CFG_REC_STRIDE, 48'(rand40()));
    write_reg(CFG_HAS_REC, 48'(rec));
    write_reg(CFG_NUM_DIMS, 48'(nd));
    used = (nd > 8) ? 8 : nd;
    bad_dim = (used > 0) ? $urandom_range(used - 1) : 0;
    for (int d = 0; d < used; d++) begin
      ex = $urandom_range(1, 4);
      st = $urandom_range(0, ex - 1);
      ed = $urandom_range(1, ex - st);
      if (rec && d == 0) begin
        st = $urandom_range(0, 12);
        ed = $urandom_range(1, 3);
      end
      if (d == bad_dim) begin
        if (flaw == 1) st = ex + $urandom_range(0, 2);
        if (flaw == 2) ed = ex - st + 1;
        if (flaw == 3) ed = 0;
      end
      load_dim(d, st, ed, ex);
    end
    if ($urandom_range(9) == 0) send_cmd(KIND_NONE, 3'($urandom), $urandom, $urandom,
                                         $urandom, rand40(), 1'($urandom_range(1)));
    send_cmd(KIND_START, 3'($urandom), $urandom, $urandom, $urandom, rand40(),
             1'($urandom_range(1)));
    for (int k = 0; k < nexts; k++)
      send_cmd(KIND_NEXT, 3'($urandom), $urandom, $urandom, $urandom, rand40(),
               1'($urandom_range(1)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: every descriptor loaded before any start
    for (int d = 0; d < 8; d++) load_dim(d, 0, 1, 1);
    // scalar variable: one run at the base address, then idle
    write_reg(CFG_NUM_DIMS, 0);
    write_reg(CFG_BASE, 48'hFFFF_FFFF_FFFF);
    send_cmd(KIND_START, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_NONE, 0, 0, 0, 0, 0, 0);
    // full-width descriptor values and strides; huge run length saturates
    write_reg(CFG_NUM_DIMS, 15);
    write_reg(CFG_REC_STRIDE, 48'h00FF_FFFF_FFFF);
    write_reg(CFG_HAS_REC, 0);
    for (int d = 0; d < 8; d++)
      send_cmd(KIND_LOAD, 3'(d), 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1);
    send_cmd(KIND_START, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1);
    send_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 0);
    send_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 0);
    // load during a transfer aborts it
    send_cmd(KIND_LOAD, 7, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0);
    send_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 0);
    // receiver holds off while the sender keeps offering loads
    hold_start = 1;
    for (int k = 0; k < 30; k++) load_dim(k % 8, 0, 1, 1);
    // record dim: read past record count, then a write that grows it
    run_transfer(2, 1, 0, 2);
    send_cmd(KIND_START, 0, 0, 0, 0, 0, 1);
    send_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 0);
    // bad edge, bad coordinates, empty slab, max dims
    run_transfer(3, 0, 2, 1);
    run_transfer(3, 0, 1, 1);
    run_transfer(3, 0, 3, 3);
    run_transfer(8, 1, 0, 4);

    // random transfers, mostly clean
    while (items_sent < 1600) begin
      int f;
      f = $urandom_range(9);
      run_transfer($urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 8),
                   1'($urandom_range(1)), (f < 7) ? 0 : f - 6, $urandom_range(1, 24));
      // stray loads to any dimension with random full-width values
      if ($urandom_range(3) == 0)
        send_cmd(KIND_LOAD, 3'($urandom), $urandom, $urandom, $urandom, rand40(),
                 1'($urandom_range(1)));
    end

    s_axis_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
